// File: design/gbt_pkg.sv
// shared types and constants of the graph traversal core
package gbt_pkg;

   localparam int VTX_W            = 6;
   localparam int OP_W             = 2;
   localparam int WORK_DEPTH       = 64;
   localparam int NUM_VERTICES_DEF = 64;
   localparam int MAX_DEGREE_DEF   = 16;

   typedef enum logic [OP_W-1:0] {
      OP_CLEAR    = 2'd0,
      OP_ADD_EDGE = 2'd1,
      OP_BFS      = 2'd2,
      OP_DFS      = 2'd3
   } opcode_type;

   typedef struct packed {
      opcode_type       opcode;
      logic [VTX_W-1:0] vertex_a;
      logic [VTX_W-1:0] vertex_b;
   } req_type;

   typedef struct packed {
      logic [VTX_W-1:0] vertex;
      logic             last;
      logic             status;
   } rsp_type;

   typedef struct packed {
      logic pend_vld;
      logic trav;
   } eng_stat_type;

endpackage

// File: design/gbt_ram.sv
// generic single-port-write ram with registered read
module gbt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/gbt_engine.sv
// command sequencer: edge insertion and bfs/dfs walks over the graph memories
module gbt_engine #(
   parameter int NUM_VERTICES = gbt_pkg::NUM_VERTICES_DEF,
   parameter int MAX_DEGREE   = gbt_pkg::MAX_DEGREE_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  gbt_pkg::req_type     req,
   output logic                 res_valid,
   input  logic                 res_ready,
   output gbt_pkg::rsp_type     res,
   output gbt_pkg::eng_stat_type stat
);

   localparam int VW   = gbt_pkg::VTX_W;
   localparam int VA_W = $clog2(NUM_VERTICES);
   localparam int NA_W = $clog2(NUM_VERTICES * MAX_DEGREE);
   localparam int DG_W = $clog2(MAX_DEGREE + 1);
   localparam int WI_W = $clog2(gbt_pkg::WORK_DEPTH);
   localparam int WP_W = $clog2(gbt_pkg::WORK_DEPTH + 1);
   localparam int WE_W = VW + DG_W;

   typedef enum logic [3:0] {
      S_IDLE, S_ACK, S_ERDA, S_ERDB, S_EWB,
      S_BPOP, S_BDEG, S_BDEGW, S_BNB, S_BNBW,
      S_DTOP, S_DTOPW, S_DDEGW, S_DNBW, S_FLUSH
   } state_type;

   state_type         state_ff;
   logic [VW-1:0]     a_ff, b_ff, cur_v_ff, pend_vtx_ff;
   logic [DG_W-1:0]   dega_ff, degb_ff, degv_ff, cur_next_ff;
   logic [WP_W-1:0]   head_ff, tail_ff, n_ff;
   logic              ack_st_ff, pend_vld_ff, deg_rv_ff;
   logic [NUM_VERTICES-1:0] vis_ff, deg_vld_ff;

   // memory ports
   logic              nbr_we;
   logic [NA_W-1:0]   nbr_waddr, nbr_raddr;
   logic [VW-1:0]     nbr_wdata, nbr_rdata;
   logic              deg_we;
   logic [VA_W-1:0]   deg_waddr, deg_raddr;
   logic [DG_W-1:0]   deg_wdata, deg_rdata;
   logic              work_we;
   logic [WI_W-1:0]   work_waddr, work_raddr;
   logic [WE_W-1:0]   work_wdata, work_rdata;

   logic [VW-1:0]     wr_vtx;
   logic [DG_W-1:0]   wr_next, deg_val;
   logic [WP_W-1:0]   tail_m1;
   logic              a_ok, b_ok, req_a_ok, self_loop, edge_ok;
   logic              w_ok, w_new, emit_req, stall;

   function automatic logic [NA_W-1:0] nbr_addr(input logic [VW-1:0] v,
                                                input logic [DG_W-1:0] s);
      return NA_W'(int'(VA_W'(v)) * MAX_DEGREE + int'(s));
   endfunction

   gbt_ram #(.WIDTH(VW), .DEPTH(NUM_VERTICES * MAX_DEGREE)) u_nbr_ram (
      .clock(clock), .wr_en(nbr_we), .wr_addr(nbr_waddr), .wr_data(nbr_wdata),
      .rd_addr(nbr_raddr), .rd_data(nbr_rdata)
   );

   gbt_ram #(.WIDTH(DG_W), .DEPTH(NUM_VERTICES)) u_deg_ram (
      .clock(clock), .wr_en(deg_we), .wr_addr(deg_waddr), .wr_data(deg_wdata),
      .rd_addr(deg_raddr), .rd_data(deg_rdata)
   );

   gbt_ram #(.WIDTH(WE_W), .DEPTH(gbt_pkg::WORK_DEPTH)) u_work_ram (
      .clock(clock), .wr_en(work_we), .wr_addr(work_waddr), .wr_data(work_wdata),
      .rd_addr(work_raddr), .rd_data(work_rdata)
   );

   always_comb begin
      wr_vtx    = work_rdata[VW-1:0];
      wr_next   = work_rdata[VW +: DG_W];
      deg_val   = deg_rv_ff ? deg_rdata : '0;
      tail_m1   = tail_ff - 1'b1;
      req_a_ok  = int'(req.vertex_a) < NUM_VERTICES;
      a_ok      = req_a_ok;
      b_ok      = int'(req.vertex_b) < NUM_VERTICES;
      self_loop = (a_ff == b_ff);
      if (self_loop) begin
         edge_ok = int'(dega_ff) + 2 <= MAX_DEGREE;
      end else begin
         edge_ok = (int'(dega_ff) < MAX_DEGREE) && (int'(deg_val) < MAX_DEGREE);
      end
      w_ok  = (int'(nbr_rdata) < NUM_VERTICES) && !vis_ff[VA_W'(nbr_rdata)] &&
              (tail_ff < WP_W'(gbt_pkg::WORK_DEPTH));
      w_new = w_ok && (n_ff < WP_W'(gbt_pkg::WORK_DEPTH));
      emit_req = (state_ff == S_BDEGW) || ((state_ff == S_DNBW) && w_new);
      stall    = emit_req && pend_vld_ff && !res_ready;

      // read addresses; the neighbor and degree reads hold while stalled
      nbr_raddr = nbr_addr(cur_v_ff, cur_next_ff);
      case (state_ff)
         S_IDLE:               deg_raddr = VA_W'(req.vertex_a);
         S_ERDA:               deg_raddr = VA_W'(b_ff);
         S_BDEG, S_DTOPW:      deg_raddr = VA_W'(wr_vtx);
         default:              deg_raddr = VA_W'(cur_v_ff);
      endcase
      if (state_ff == S_DTOP || state_ff == S_DTOPW) begin
         work_raddr = tail_m1[WI_W-1:0];
      end else begin
         work_raddr = head_ff[WI_W-1:0];
      end

      nbr_we     = 1'b0;
      nbr_waddr  = nbr_addr(a_ff, dega_ff);
      nbr_wdata  = b_ff;
      deg_we     = 1'b0;
      deg_waddr  = VA_W'(a_ff);
      deg_wdata  = DG_W'(dega_ff + 1'b1);
      work_we    = 1'b0;
      work_waddr = tail_ff[WI_W-1:0];
      work_wdata = {{DG_W{1'b0}}, nbr_rdata};
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_a_ok &&
                (req.opcode == gbt_pkg::OP_BFS || req.opcode == gbt_pkg::OP_DFS)) begin
               work_we    = 1'b1;
               work_waddr = '0;
               work_wdata = {{DG_W{1'b0}}, req.vertex_a};
            end
         end
         S_ERDB: begin
            nbr_we = edge_ok;
            deg_we = edge_ok;
         end
         S_EWB: begin
            nbr_we = 1'b1;
            deg_we = 1'b1;
            if (self_loop) begin
               nbr_waddr = nbr_addr(a_ff, DG_W'(dega_ff + 1'b1));
               nbr_wdata = a_ff;
               deg_wdata = DG_W'(dega_ff + 2'd2);
            end else begin
               nbr_waddr = nbr_addr(b_ff, degb_ff);
               nbr_wdata = a_ff;
               deg_waddr = VA_W'(b_ff);
               deg_wdata = DG_W'(degb_ff + 1'b1);
            end
         end
         S_BNBW: work_we = w_ok;
         S_DDEGW: begin
            // advance the top entry's neighbor index
            work_we    = (cur_next_ff < deg_val);
            work_waddr = tail_m1[WI_W-1:0];
            work_wdata = {DG_W'(cur_next_ff + 1'b1), cur_v_ff};
         end
         S_DNBW: work_we = w_new && !stall;
         default: ;
      endcase

      req_ready = (state_ff == S_IDLE);
      res_valid = (state_ff == S_ACK) || (state_ff == S_FLUSH) || (emit_req && pend_vld_ff);
      if (state_ff == S_ACK) begin
         res.vertex = '0;
         res.last   = 1'b1;
         res.status = ack_st_ff;
      end else begin
         res.vertex = pend_vtx_ff;
         res.last   = (state_ff == S_FLUSH);
         res.status = 1'b0;
      end
      stat.pend_vld = pend_vld_ff;
      stat.trav     = (state_ff != S_IDLE) && (state_ff != S_ACK) && (state_ff != S_ERDA) &&
                      (state_ff != S_ERDB) && (state_ff != S_EWB);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         pend_vld_ff <= 1'b0;
         vis_ff      <= '0;
         deg_vld_ff  <= '0;
         deg_rv_ff   <= 1'b0;
         head_ff     <= '0;
         tail_ff     <= '0;
         n_ff        <= '0;
      end else begin
         deg_rv_ff <= deg_vld_ff[deg_raddr];
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  a_ff <= req.vertex_a;
                  b_ff <= req.vertex_b;
                  case (req.opcode)
                     gbt_pkg::OP_CLEAR: begin
                        deg_vld_ff <= '0;
                        ack_st_ff  <= 1'b0;
                        state_ff   <= S_ACK;
                     end
                     gbt_pkg::OP_ADD_EDGE: begin
                        if (a_ok && b_ok) begin
                           state_ff <= S_ERDA;
                        end else begin
                           ack_st_ff <= 1'b1;
                           state_ff  <= S_ACK;
                        end
                     end
                     gbt_pkg::OP_BFS, gbt_pkg::OP_DFS: begin
                        if (req_a_ok) begin
                           // only the start vertex is marked
                           vis_ff  <= NUM_VERTICES'(1) << VA_W'(req.vertex_a);
                           head_ff <= '0;
                           tail_ff <= WP_W'(1);
                           if (req.opcode == gbt_pkg::OP_BFS) begin
                              n_ff     <= '0;
                              state_ff <= S_BPOP;
                           end else begin
                              n_ff        <= WP_W'(1);
                              pend_vld_ff <= 1'b1;
                              pend_vtx_ff <= req.vertex_a;
                              state_ff    <= S_DTOP;
                           end
                        end
                     end
                     default: state_ff <= S_IDLE;
                  endcase
               end
            end
            S_ERDA: begin
               dega_ff  <= deg_val;
               state_ff <= S_ERDB;
            end
            S_ERDB: begin
               degb_ff <= deg_val;
               if (edge_ok) begin
                  deg_vld_ff[VA_W'(a_ff)] <= 1'b1;
                  state_ff                <= S_EWB;
               end else begin
                  ack_st_ff <= 1'b1;
                  state_ff  <= S_ACK;
               end
            end
            S_EWB: begin
               deg_vld_ff[VA_W'(b_ff)] <= 1'b1;
               ack_st_ff               <= 1'b0;
               state_ff                <= S_ACK;
            end
            S_ACK: begin
               if (res_ready) begin
                  state_ff <= S_IDLE;
               end
            end
            S_BPOP: begin
               if (head_ff < tail_ff && n_ff < WP_W'(gbt_pkg::WORK_DEPTH)) begin
                  state_ff <= S_BDEG;
               end else begin
                  state_ff <= S_FLUSH;
               end
            end
            S_BDEG: begin
               cur_v_ff <= wr_vtx;
               head_ff  <= head_ff + 1'b1;
               state_ff <= S_BDEGW;
            end
            S_BDEGW: begin
               if (!stall) begin
                  pend_vld_ff <= 1'b1;
                  pend_vtx_ff <= cur_v_ff;
                  n_ff        <= n_ff + 1'b1;
                  degv_ff     <= deg_val;
                  cur_next_ff <= '0;
                  state_ff    <= S_BNB;
               end
            end
            S_BNB: begin
               if (cur_next_ff < degv_ff) begin
                  state_ff <= S_BNBW;
               end else begin
                  state_ff <= S_BPOP;
               end
            end
            S_BNBW: begin
               if (w_ok) begin
                  vis_ff[VA_W'(nbr_rdata)] <= 1'b1;
                  tail_ff                  <= tail_ff + 1'b1;
               end
               cur_next_ff <= cur_next_ff + 1'b1;
               state_ff    <= S_BNB;
            end
            S_DTOP: begin
               if (tail_ff != '0) begin
                  state_ff <= S_DTOPW;
               end else begin
                  state_ff <= S_FLUSH;
               end
            end
            S_DTOPW: begin
               cur_v_ff    <= wr_vtx;
               cur_next_ff <= wr_next;
               state_ff    <= S_DDEGW;
            end
            S_DDEGW: begin
               if (cur_next_ff < deg_val) begin
                  state_ff <= S_DNBW;
               end else begin
                  tail_ff  <= tail_m1;
                  state_ff <= S_DTOP;
               end
            end
            S_DNBW: begin
               if (!stall) begin
                  if (w_new) begin
                     vis_ff[VA_W'(nbr_rdata)] <= 1'b1;
                     tail_ff                  <= tail_ff + 1'b1;
                     n_ff                     <= n_ff + 1'b1;
                     pend_vld_ff              <= 1'b1;
                     pend_vtx_ff              <= nbr_rdata;
                  end
                  state_ff <= S_DTOP;
               end
            end
            S_FLUSH: begin
               if (res_ready) begin
                  pend_vld_ff <= 1'b0;
                  state_ff    <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// File: design/graph_bfs_dfs_traversal_core.sv
// top level of the graph store with breadth-first and depth-first traversal
//
// usage: one command transfer on req_ (tuser = opcode, tdata = vertex_a, vertex_b)
// gives results on rsp_. clear and add-edge give one acknowledgment (vertex 0,
// tlast 1, tuser = reject flag). a traversal gives every vertex reachable from
// vertex_a in visit order, tlast on the final one; a start vertex outside the
// graph gives no result at all.
// throughput: one command at a time; req_tready is high only while the
// sequencer is idle. the cost of a command is set by the single read port of
// the neighbor, degree and work list memories, each with a registered read.
// a result is held in the output register; a traversal vertex is held back
// by one emission so that tlast can be set on the final one.
// reset clears the degree valid bits (empty graph) and the sequencer; no
// clearing pass is needed. when rsp_tready is low the output register holds
// and the sequencer stops at its next emission.
module graph_bfs_dfs_traversal_core #(
   parameter int NUM_VERTICES = gbt_pkg::NUM_VERTICES_DEF,
   parameter int MAX_DEGREE   = gbt_pkg::MAX_DEGREE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // vertex_a [5:0], vertex_b [11:6], zero fill
   input  logic [1:0]  req_tuser,   // opcode [1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // vertex [5:0], zero fill
   output logic        rsp_tlast,
   output logic        rsp_tuser    // status [0]
);

   gbt_pkg::req_type      req;
   gbt_pkg::rsp_type      eng_res;
   gbt_pkg::rsp_type      out_ff;
   gbt_pkg::eng_stat_type eng_st;
   logic                  eng_res_valid, eng_res_ready, out_vld_ff;

   // unpack the command transfer
   always_comb begin
      req.opcode   = gbt_pkg::opcode_type'(req_tuser);
      req.vertex_a = req_tdata[5:0];
      req.vertex_b = req_tdata[11:6];
   end

   gbt_engine #(.NUM_VERTICES(NUM_VERTICES), .MAX_DEGREE(MAX_DEGREE)) u_engine (
      .clock(clock), .reset(reset),
      .req_valid(req_tvalid), .req_ready(req_tready), .req(req),
      .res_valid(eng_res_valid), .res_ready(eng_res_ready), .res(eng_res),
      .stat(eng_st)
   );

   // output register: refills in the same cycle the held result leaves
   assign eng_res_ready = !out_vld_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (eng_res_ready) begin
         out_vld_ff <= eng_res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (eng_res_ready && eng_res_valid) begin
         out_ff <= eng_res;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {2'b00, out_ff.vertex};
   assign rsp_tlast  = out_ff.last;
   assign rsp_tuser  = out_ff.status;

   // a new command never starts while a traversal vertex is still held back
   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !eng_st.pend_vld)
      else $error("command accepted with a held traversal result");

   // a result offered by the sequencer stays offered until taken
   a_res_hold: assert property (@(posedge clock) disable iff (reset)
      eng_res_valid && !eng_res_ready |=> eng_res_valid)
      else $error("sequencer dropped a result");

   // rejections come only from edge commands and always end the command
   a_reject_ack: assert property (@(posedge clock) disable iff (reset)
      eng_res_valid && eng_res.status |-> eng_res.last && !eng_st.trav)
      else $error("reject flag outside an edge acknowledgment");

   // rejected acknowledgments carry tlast and vertex zero
   a_out_reject_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast && (rsp_tdata == 8'd0))
      else $error("reject transfer without tlast or with a vertex");

endmodule

// File: test/graph_bfs_dfs_traversal_core_checker.sv
// checker: predicts traversal core results from accepted commands and compares them
`timescale 1ns / 100ps

module graph_bfs_dfs_traversal_core_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,
   input  logic        rsp_tlast,
   input  logic        rsp_tuser,
   output int          fail_count,
   output int          pending_count
);

   localparam int NV = gbt_pkg::NUM_VERTICES_DEF;
   localparam int MD = gbt_pkg::MAX_DEGREE_DEF;
   localparam int VW = gbt_pkg::VTX_W;

   logic [VW-1:0]     adj [NV][MD];
   int                degree [NV];
   gbt_pkg::rsp_type  expected_rsp [$];

   assign pending_count = expected_rsp.size();

   function automatic gbt_pkg::rsp_type make_rsp(logic [VW-1:0] v, logic l, logic s);
      gbt_pkg::rsp_type r;
      r.vertex = v;
      r.last   = l;
      r.status = s;
      return r;
   endfunction

   task automatic predict_add(int a, int b);
      logic ok;
      if (a == b)
         ok = (degree[a] + 2 <= MD);
      else
         ok = (degree[a] < MD) && (degree[b] < MD);
      if (ok) begin
         adj[a][degree[a]] = VW'(b);
         degree[a]++;
         adj[b][degree[b]] = VW'(a);
         degree[b]++;
      end
      expected_rsp.push_back(make_rsp('0, 1'b1, !ok));
   endtask

   task automatic predict_bfs(int s);
      logic seen [NV];
      int   fifo [$];
      int   order [$];
      int   v;
      foreach (seen[i]) seen[i] = 1'b0;
      fifo.push_back(s);
      seen[s] = 1'b1;
      while (fifo.size() > 0) begin
         v = fifo.pop_front();
         order.push_back(v);
         for (int i = 0; i < degree[v]; i++)
            if (!seen[adj[v][i]]) begin
               seen[adj[v][i]] = 1'b1;
               fifo.push_back(int'(adj[v][i]));
            end
      end
      foreach (order[i])
         expected_rsp.push_back(make_rsp(VW'(order[i]), i == order.size() - 1, 1'b0));
   endtask

   // explicit stack of (vertex, next neighbor index) keeps the recursive order
   task automatic predict_dfs(int s);
      logic seen [NV];
      int   stk_v [$];
      int   stk_n [$];
      int   order [$];
      int   v, w, t;
      foreach (seen[i]) seen[i] = 1'b0;
      seen[s] = 1'b1;
      order.push_back(s);
      stk_v.push_back(s);
      stk_n.push_back(0);
      while (stk_v.size() > 0) begin
         t = stk_v.size() - 1;
         v = stk_v[t];
         if (stk_n[t] < degree[v]) begin
            w = int'(adj[v][stk_n[t]]);
            stk_n[t]++;
            if (!seen[w]) begin
               seen[w] = 1'b1;
               order.push_back(w);
               stk_v.push_back(w);
               stk_n.push_back(0);
            end
         end else begin
            void'(stk_v.pop_back());
            void'(stk_n.pop_back());
         end
      end
      foreach (order[i])
         expected_rsp.push_back(make_rsp(VW'(order[i]), i == order.size() - 1, 1'b0));
   endtask

   always @(posedge clock) begin
      gbt_pkg::rsp_type got, want;
      if (reset) begin
         foreach (degree[i]) degree[i] = 0;
         expected_rsp.delete();
         fail_count <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = make_rsp(rsp_tdata[5:0], rsp_tlast, rsp_tuser);
            if (expected_rsp.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected result transfer: vertex %0d last %0b status %0b",
                           got.vertex, got.last, got.status);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_rsp.pop_front();
               if (got !== want || rsp_tdata[7:6] !== 2'b00) begin
                  if (fail_count < 10)
                     $display("result mismatch: expected v %0d l %0b s %0b, got v %0d l %0b s %0b",
                              want.vertex, want.last, want.status,
                              got.vertex, got.last, got.status);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            case (gbt_pkg::opcode_type'(req_tuser))
               gbt_pkg::OP_CLEAR: begin
                  foreach (degree[i]) degree[i] = 0;
                  expected_rsp.push_back(make_rsp('0, 1'b1, 1'b0));
               end
               gbt_pkg::OP_ADD_EDGE: predict_add(int'(req_tdata[5:0]), int'(req_tdata[11:6]));
               gbt_pkg::OP_BFS:      predict_bfs(int'(req_tdata[5:0]));
               default:              predict_dfs(int'(req_tdata[5:0]));
            endcase
         end
      end
   end

endmodule

// File: test/graph_bfs_dfs_traversal_core_tb.sv
// testbench top: command stimulus, reset, watchdog and verdict for the traversal core
`timescale 1ns / 100ps

module graph_bfs_dfs_traversal_core_tb;

   localparam int IDLE_LIMIT = 20000;   // cycles with no transfer before giving up

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;
   int          fail_count;
   int          pending_count;
   int          idle_cycles;
   int          burst_left;
   int          stall_mode;

   graph_bfs_dfs_traversal_core DUT (.*);

   graph_bfs_dfs_traversal_core_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver stalls: phases of always-ready, random and mostly-stalled
   initial begin
      rsp_tready = 1'b0;
      stall_mode = 0;
      forever begin
         @(posedge clock);
         if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
         case (stall_mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= 1'($urandom_range(0, 1));
            default: rsp_tready <= ($urandom_range(0, 4) == 0);
         endcase
      end
   end

   // watchdog on cycles with no transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL graph_bfs_dfs_traversal_core");
         $finish;
      end
   end

   // one command transfer; random gaps between bursts from the sender
   task automatic send_cmd(gbt_pkg::opcode_type op, logic [5:0] a, logic [5:0] b);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = $urandom_range(1, 10);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'b0, b, a};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   int          items;
   int          nv;
   logic [5:0]  va, vb;
   int          pick;

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = gbt_pkg::OP_CLEAR;
      burst_left = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty graph walks, extreme vertices, self loops, full list
      send_cmd(gbt_pkg::OP_BFS, 6'd0, 6'd0);
      send_cmd(gbt_pkg::OP_DFS, 6'd63, 6'd63);
      send_cmd(gbt_pkg::OP_ADD_EDGE, 6'd0, 6'd63);
      send_cmd(gbt_pkg::OP_ADD_EDGE, 6'd63, 6'd63);
      send_cmd(gbt_pkg::OP_ADD_EDGE, 6'd63, 6'd21);
      send_cmd(gbt_pkg::OP_ADD_EDGE, 6'd21, 6'd42);
      send_cmd(gbt_pkg::OP_ADD_EDGE, 6'd0, 6'd63);
      send_cmd(gbt_pkg::OP_BFS, 6'd0, 6'd42);
      send_cmd(gbt_pkg::OP_DFS, 6'd0, 6'd21);
      for (int i = 0; i < 8; i++) send_cmd(gbt_pkg::OP_ADD_EDGE, 6'd5, 6'd5);   // last one fills the list
      send_cmd(gbt_pkg::OP_ADD_EDGE, 6'd5, 6'd6);                               // rejected, list full
      send_cmd(gbt_pkg::OP_DFS, 6'd5, 6'd0);
      send_cmd(gbt_pkg::OP_CLEAR, 6'd63, 6'd63);
      send_cmd(gbt_pkg::OP_BFS, 6'd63, 6'd0);
      drain();   // sender holds off until all results have come

      // random: clear, build a graph of random size, then walk it a few times
      items = 0;
      while (items < 270) begin
         nv = (stall_mode == 2) ? $urandom_range(2, 12) : $urandom_range(2, 64);
         send_cmd(gbt_pkg::OP_CLEAR, 6'($urandom), 6'($urandom));
         items++;
         repeat ($urandom_range(4, 40)) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
               va = 6'($urandom); vb = 6'($urandom);   // anywhere, may hit full lists
            end else if (pick == 1) begin
               va = 6'($urandom_range(0, nv - 1)); vb = va;
            end else begin
               va = 6'($urandom_range(0, nv - 1)); vb = 6'($urandom_range(0, nv - 1));
            end
            send_cmd(gbt_pkg::OP_ADD_EDGE, va, vb);
            items++;
         end
         repeat ($urandom_range(1, 4)) begin
            send_cmd($urandom_range(0, 1) ? gbt_pkg::OP_BFS : gbt_pkg::OP_DFS,
                     ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, nv - 1)),
                     6'($urandom));
            items++;
         end
      end
      drain();

      if (fail_count == 0)
         $display("PASS graph_bfs_dfs_traversal_core");
      else
         $display("FAIL graph_bfs_dfs_traversal_core");
      $finish;
   end

endmodule
